>>> hw/rtl/lzss_pkg.sv
package lzss_pkg;
    localparam int unsigned HistDepth = 32768;
    localparam int unsigned HistAw    = $clog2(HistDepth);
    localparam int unsigned OutLanes  = 8;
    localparam int unsigned LaneAw    = (OutLanes > 1) ? $clog2(OutLanes) : 1;

    localparam logic [1:0] StOk    = 2'd0;
    localparam logic [1:0] StEarly = 2'd1;
    localparam logic [1:0] StDist  = 2'd2;

    localparam logic [23:0] SizeReset = 24'd65536;

    // decoder phases
    typedef enum logic [6:0] {
        PH_IDLE  = 7'b0000001,
        PH_FLAG  = 7'b0000010,
        PH_LIT   = 7'b0000100,
        PH_LEN   = 7'b0001000,
        PH_DIST1 = 7'b0010000,
        PH_DIST2 = 7'b0100000,
        PH_DONE  = 7'b1000000
    } t_phase;

    // sequencer states
    typedef enum logic [3:0] {
        S_IN   = 4'b0001,
        S_COPY = 4'b0010,
        S_EMIT = 4'b0100,
        S_WAIT = 4'b1000
    } t_seq;

    typedef struct packed {
        logic [8*OutLanes-1:0] out_bytes;
        logic [3:0]            byte_count;
        logic                  last;
        logic [1:0]            status;
    } t_out;

    typedef struct packed {
        logic       start_req;
        logic [7:0] in_byte;
        logic       last_in;
    } t_in;
endpackage

>>> hw/rtl/lzss_if.sv
interface lzss_in_if;
    logic            valid;
    logic            ready;
    lzss_pkg::t_in   data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface lzss_out_if;
    logic            valid;
    logic            ready;
    lzss_pkg::t_out  data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> hw/rtl/lzss_ram.sv
module lzss_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 32768
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

>>> hw/rtl/lzss_flag_byte_decompressor_top.sv
// LZSS decompressor taking one compressed byte per transaction and producing
// packed results of up to eight bytes. A literal is written to the history
// and then handed off as a result. A match copies one byte at a time through
// the 32 KiB history RAM (a registered read, then the write of that byte; the
// next read follows the write, so overlapping source and destination need no
// forwarding). Each full result is handed off before the copy goes on, and
// every result waits for as long as the receiver stalls. Input is held off
// until the step's last result has been loaded into the output register.
// No clearing pass is needed: the history is only read where written.
module lzss_flag_byte_decompressor_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_cfg_we,
    input  logic [23:0]    i_cfg_wdata,
    lzss_in_if.sink        i_in,
    lzss_out_if.source     o_out
);
    localparam int unsigned Aw = lzss_pkg::HistAw;
    localparam int unsigned Nl = lzss_pkg::OutLanes;
    localparam int unsigned La = lzss_pkg::LaneAw;

    logic [23:0]          r_size;
    lzss_pkg::t_phase     r_phase;
    lzss_pkg::t_seq       r_seq;
    logic [Aw-1:0]        r_wp;
    logic                 r_full;
    logic [23:0]          r_rem;
    logic [7:0]           r_flags;
    logic [2:0]           r_tok;
    logic [8:0]           r_mlen;
    logic [6:0]           r_dhi;
    // copy engine
    logic [8:0]           r_cnt;
    logic [Aw-1:0]        r_src;
    logic                 r_rd_pend;
    logic                 r_term;
    logic [1:0]           r_stat;
    // packing
    logic [8*Nl-1:0]      r_pack;
    logic [3:0]           r_np;
    lzss_pkg::t_out       r_out;
    logic                 r_ov;

    logic                 we;
    logic [Aw-1:0]        raddr;
    logic [7:0]           rdata;
    logic [7:0]           wbyte;
    logic [Aw:0]          avail;
    logic [15:0]          match_dist;

    lzss_ram #(.Width(8), .Depth(lzss_pkg::HistDepth)) u_hist (
        .i_clk  (i_clk),
        .i_we   (we),
        .i_waddr(r_wp),
        .i_wdata(wbyte),
        .i_raddr(raddr),
        .o_rdata(rdata)
    );

    logic acc, out_free;
    assign out_free = !r_ov || o_out.ready;
    assign i_in.ready = (r_seq == lzss_pkg::S_IN) && out_free;
    assign acc = i_in.valid && i_in.ready;
    assign o_out.valid = r_ov;
    assign o_out.data  = r_out;

    // next token phase once a token completes
    function automatic lzss_pkg::t_phase next_tok(input logic [2:0] t,
                                                  input logic [7:0] f);
        logic [2:0] nt;
        nt = t + 3'd1;
        if (nt == 3'd0) return lzss_pkg::PH_FLAG;
        return f[nt] ? lzss_pkg::PH_LEN : lzss_pkg::PH_LIT;
    endfunction

    assign avail = r_full ? (Aw+1)'(lzss_pkg::HistDepth) : {1'b0, r_wp};

    // history write: copied byte from the RAM, or the literal
    assign wbyte = (r_seq == lzss_pkg::S_COPY) ? rdata : i_in.data.in_byte;
    assign we = (r_seq == lzss_pkg::S_COPY) ? (r_rd_pend && r_np != 4'(Nl))
              : (acc && r_phase == lzss_pkg::PH_LIT && !i_in.data.start_req);
    assign raddr = r_src;

    // distance of the current match token
    always_comb begin
        if (r_phase == lzss_pkg::PH_DIST2) begin
            match_dist = {1'b0, r_dhi, i_in.data.in_byte} + 16'd1;
        end else begin
            match_dist = {9'd0, i_in.data.in_byte[6:0]} + 16'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        logic n_ov;
        n_ov = r_ov && !o_out.ready;
        if (!i_rst_n) begin
            r_size  <= lzss_pkg::SizeReset;
            r_phase <= lzss_pkg::PH_IDLE;
            r_seq   <= lzss_pkg::S_IN;
            r_ov    <= 1'b0;
            r_wp    <= '0;
            r_full  <= 1'b0;
            r_rem   <= '0;
            r_tok   <= '0;
            r_flags <= '0;
            r_np    <= '0;
            r_rd_pend <= 1'b0;
        end else begin
            if (i_cfg_we) r_size <= i_cfg_wdata;
            if (we) begin
                r_wp <= r_wp + 1'b1;
                if (&r_wp) r_full <= 1'b1;
            end
            unique case (r_seq)
                lzss_pkg::S_IN: if (acc) begin
                    logic              st;
                    lzss_pkg::t_phase  ph;
                    logic [7:0]        b;
                    logic [8:0]        len;
                    b = i_in.data.in_byte;
                    st = i_in.data.start_req;
                    ph = r_phase;
                    if (st) begin
                        r_rem <= r_size; r_wp <= '0; r_full <= 1'b0;
                        r_tok <= '0; r_mlen <= '0; r_dhi <= '0;
                        ph = lzss_pkg::PH_FLAG;
                    end
                    if (st && r_size == 24'd0) begin
                        r_flags <= '0;
                        r_phase <= lzss_pkg::PH_DONE;
                        r_out <= '{out_bytes: '0, byte_count: 4'd0, last: 1'b1,
                                   status: lzss_pkg::StOk};
                        n_ov = 1'b1;
                    end else begin
                        unique case (ph)
                            lzss_pkg::PH_FLAG: begin
                                r_flags <= b;
                                if (i_in.data.last_in) begin
                                    r_phase <= lzss_pkg::PH_DONE;
                                    r_out <= '{out_bytes: '0, byte_count: 4'd0,
                                               last: 1'b1, status: lzss_pkg::StEarly};
                                    n_ov = 1'b1;
                                end else begin
                                    r_phase <= b[0] ? lzss_pkg::PH_LEN : lzss_pkg::PH_LIT;
                                end
                            end
                            lzss_pkg::PH_LEN: begin
                                r_mlen <= {1'b0, b} + 9'd3;
                                if (i_in.data.last_in) begin
                                    r_phase <= lzss_pkg::PH_DONE;
                                    r_out <= '{out_bytes: '0, byte_count: 4'd0,
                                               last: 1'b1, status: lzss_pkg::StEarly};
                                    n_ov = 1'b1;
                                end else r_phase <= lzss_pkg::PH_DIST1;
                            end
                            lzss_pkg::PH_LIT: begin
                                r_rem <= r_rem - 24'd1;
                                r_tok <= r_tok + 3'd1;
                                r_term <= (r_rem == 24'd1) || i_in.data.last_in;
                                r_stat <= (r_rem == 24'd1) ? lzss_pkg::StOk
                                                           : lzss_pkg::StEarly;
                                r_phase <= ((r_rem == 24'd1) || i_in.data.last_in)
                                    ? lzss_pkg::PH_DONE : next_tok(r_tok, r_flags);
                                r_pack <= {{(8*(Nl-1)){1'b0}}, b};
                                r_np <= 4'd1;
                                r_seq <= lzss_pkg::S_EMIT;
                            end
                            lzss_pkg::PH_DIST1, lzss_pkg::PH_DIST2: begin
                                if (ph == lzss_pkg::PH_DIST1 && b[7]) begin
                                    r_dhi <= b[6:0];
                                    if (i_in.data.last_in) begin
                                        r_phase <= lzss_pkg::PH_DONE;
                                        r_out <= '{out_bytes: '0, byte_count: 4'd0,
                                                   last: 1'b1, status: lzss_pkg::StEarly};
                                        n_ov = 1'b1;
                                    end else r_phase <= lzss_pkg::PH_DIST2;
                                end else begin
                                    len = (24'(r_mlen) > r_rem) ? r_rem[8:0] : r_mlen;
                                    r_rem <= r_rem - 24'(len);
                                    r_pack <= '0;
                                    r_np <= '0;
                                    if ({1'b0, match_dist} > 17'(avail)) begin
                                        r_phase <= lzss_pkg::PH_DONE;
                                        r_out <= '{out_bytes: '0, byte_count: 4'd0,
                                                   last: 1'b1, status: lzss_pkg::StDist};
                                        n_ov = 1'b1;
                                    end else begin
                                        r_tok <= r_tok + 3'd1;
                                        r_term <= (r_rem == 24'(len)) || i_in.data.last_in;
                                        r_stat <= (r_rem == 24'(len)) ? lzss_pkg::StOk
                                                                      : lzss_pkg::StEarly;
                                        r_phase <= ((r_rem == 24'(len)) || i_in.data.last_in)
                                            ? lzss_pkg::PH_DONE : next_tok(r_tok, r_flags);
                                        r_src <= r_wp - Aw'(match_dist);
                                        r_cnt <= len;
                                        r_rd_pend <= 1'b0;
                                        r_seq <= (len == 9'd0) ? lzss_pkg::S_EMIT
                                                               : lzss_pkg::S_COPY;
                                    end
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                lzss_pkg::S_COPY: begin
                    // pack buffer full: hand it off before continuing
                    if (r_np == 4'(Nl)) begin
                        if (out_free) begin
                            r_out <= '{out_bytes: r_pack, byte_count: 4'(Nl),
                                       last: 1'b0, status: lzss_pkg::StOk};
                            n_ov = 1'b1;
                            r_np <= '0;
                            r_pack <= '0;
                        end
                    end else if (r_rd_pend) begin
                        r_pack[8*La'(r_np[La-1:0]) +: 8] <= wbyte;
                        r_np <= r_np + 4'd1;
                        r_cnt <= r_cnt - 9'd1;
                        r_src <= r_src + 1'b1;
                        r_rd_pend <= 1'b0;
                        if (r_cnt == 9'd1) r_seq <= lzss_pkg::S_EMIT;
                    end else begin
                        r_rd_pend <= 1'b1;
                    end
                end
                lzss_pkg::S_EMIT: begin
                    if (out_free) begin
                        if (r_np != 4'd0 || r_term) begin
                            r_out <= '{out_bytes: r_pack, byte_count: r_np,
                                       last: r_term, status: r_term ? r_stat
                                                                    : lzss_pkg::StOk};
                            n_ov = 1'b1;
                        end
                        r_seq <= lzss_pkg::S_IN;
                    end
                end
                default: r_seq <= lzss_pkg::S_IN;
            endcase
            r_ov <= n_ov;
        end
    end
endmodule

>>> hw/rtl/lzss_checker.sv
module lzss_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_valid,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [3:0]  i_out_count,
    input logic        i_out_last,
    input logic [1:0]  i_out_status
);
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_count <= 4'(lzss_pkg::OutLanes))
        else $error("byte count too large");
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status != lzss_pkg::StOk) |-> i_out_last)
        else $error("error status without last");
    a_dist_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_status == lzss_pkg::StDist) |-> i_out_count == 4'd0)
        else $error("distance error carries bytes");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid && $stable(i_out_count))
        else $error("stalled result changed");
    // input is only taken when the output register can move on
    a_in_gated: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready && i_out_valid) |-> i_out_ready)
        else $error("input taken while a result is stuck");
endmodule

bind lzss_flag_byte_decompressor_top lzss_props u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_valid(i_in.valid), .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid), .i_out_ready(o_out.ready),
    .i_out_count(o_out.data.byte_count), .i_out_last(o_out.data.last),
    .i_out_status(o_out.data.status)
);

>>> dv/lzss_checker.sv
`timescale 1ns / 100ps
module lzss_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [23:0] i_cfg_wdata,
    lzss_in_if          i_in,
    lzss_out_if         i_out,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_results_seen
);
    // predictor state
    logic [7:0]        hist_mem [lzss_pkg::HistDepth];
    logic [14:0]       wr_ptr;
    logic              hist_wrapped;
    logic [23:0]       bytes_left;
    logic [7:0]        flags;
    logic [2:0]        token_idx;
    lzss_pkg::t_phase  dec_phase;
    logic [8:0]        match_len;
    logic [6:0]        dist_hi;
    logic [23:0]       size_reg;

    lzss_pkg::t_out    expected_q[$];
    logic [7:0]        step_bytes[$];

    assign o_pending = expected_q.size();

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        o_fail_count++;
    endtask

    task automatic emit_byte(input logic [7:0] b);
        hist_mem[wr_ptr] = b;
        wr_ptr++;
        if (wr_ptr == 0) hist_wrapped = 1'b1;
        step_bytes.insert(step_bytes.size(), b);
    endtask

    // finishes a token; returns 1 when the stream is complete
    function automatic bit close_token();
        token_idx++;
        if (bytes_left == 0) return 1'b1;
        if (token_idx == 0) dec_phase = lzss_pkg::PH_FLAG;
        else dec_phase = flags[token_idx] ? lzss_pkg::PH_LEN : lzss_pkg::PH_LIT;
        return 1'b0;
    endfunction

    task automatic copy_match(input int unsigned mdist, output logic [1:0] st);
        int unsigned len;
        int unsigned avail;
        len   = match_len;
        avail = hist_wrapped ? lzss_pkg::HistDepth : wr_ptr;
        if (len > bytes_left) len = bytes_left;
        bytes_left -= len;
        st = lzss_pkg::StOk;
        if (mdist > avail) begin
            st = lzss_pkg::StDist;
        end else begin
            for (int k = 0; k < len; k++) emit_byte(hist_mem[15'(wr_ptr - mdist)]);
        end
    endtask

    task automatic decode_byte(input lzss_pkg::t_in it);
        bit              term;
        logic [1:0]      st;
        lzss_pkg::t_out  r;
        int              pos;
        int              n;
        term = 0;
        st   = lzss_pkg::StOk;
        step_bytes.delete();
        if (it.start_req) begin
            bytes_left = size_reg;
            wr_ptr = 0; hist_wrapped = 0; token_idx = 0; flags = 0;
            match_len = 0; dist_hi = 0; dec_phase = lzss_pkg::PH_FLAG;
            if (size_reg == 0) begin
                dec_phase = lzss_pkg::PH_DONE;
                r = '0; r.last = 1'b1;
                expected_q.insert(expected_q.size(), r);
                return;
            end
        end else if (dec_phase == lzss_pkg::PH_IDLE || dec_phase == lzss_pkg::PH_DONE) begin
            return;
        end
        case (dec_phase)
            lzss_pkg::PH_FLAG: begin
                flags = it.in_byte;
                dec_phase = it.in_byte[0] ? lzss_pkg::PH_LEN : lzss_pkg::PH_LIT;
            end
            lzss_pkg::PH_LIT: begin
                emit_byte(it.in_byte);
                bytes_left--;
                term = close_token();
            end
            lzss_pkg::PH_LEN: begin
                match_len = it.in_byte + 9'd3;
                dec_phase = lzss_pkg::PH_DIST1;
            end
            lzss_pkg::PH_DIST1: begin
                dist_hi = it.in_byte[6:0];
                if (it.in_byte[7]) begin
                    dec_phase = lzss_pkg::PH_DIST2;
                end else begin
                    copy_match(it.in_byte[6:0] + 1, st);
                    term = (st != lzss_pkg::StOk) ? 1'b1 : close_token();
                end
            end
            default: begin
                copy_match({dist_hi, it.in_byte} + 1, st);
                term = (st != lzss_pkg::StOk) ? 1'b1 : close_token();
            end
        endcase
        if (!term && it.last_in) begin
            term = 1'b1;
            st = lzss_pkg::StEarly;
        end
        if (term) dec_phase = lzss_pkg::PH_DONE;
        if (step_bytes.size() == 0 && !term) return;
        pos = 0;
        do begin
            n = step_bytes.size() - pos;
            if (n > lzss_pkg::OutLanes) n = lzss_pkg::OutLanes;
            r = '0;
            for (int i = 0; i < n; i++) r.out_bytes[8*i +: 8] = step_bytes[pos + i];
            pos += n;
            r.byte_count = 4'(n);
            r.last   = (pos >= step_bytes.size()) && term;
            r.status = r.last ? st : lzss_pkg::StOk;
            expected_q.insert(expected_q.size(), r);
        end while (pos < step_bytes.size());
    endtask

    // watch both channels and the register port
    always @(posedge i_clk) begin
        lzss_pkg::t_out exp_r;
        if (!i_rst_n) begin
            o_fail_count   = 0;
            o_results_seen = 0;
            wr_ptr = 0; hist_wrapped = 0; bytes_left = 0; flags = 0; token_idx = 0;
            dec_phase = lzss_pkg::PH_IDLE; match_len = 0; dist_hi = 0;
            size_reg = lzss_pkg::SizeReset;
            expected_q.delete();
        end else begin
            if (i_cfg_we) size_reg = i_cfg_wdata;
            if (i_in.valid && i_in.ready) decode_byte(i_in.data);
            if (i_out.valid && i_out.ready) begin
                o_results_seen++;
                if (expected_q.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", i_out.data));
                end else begin
                    exp_r = expected_q.pop_front();
                    if (i_out.data.out_bytes !== exp_r.out_bytes)
                        report_mismatch($sformatf("out_bytes %h, want %h",
                            i_out.data.out_bytes, exp_r.out_bytes));
                    if (i_out.data.byte_count !== exp_r.byte_count)
                        report_mismatch($sformatf("byte_count %0d, want %0d",
                            i_out.data.byte_count, exp_r.byte_count));
                    if (i_out.data.last !== exp_r.last)
                        report_mismatch($sformatf("last %b, want %b",
                            i_out.data.last, exp_r.last));
                    if (i_out.data.status !== exp_r.status)
                        report_mismatch($sformatf("status %0d, want %0d",
                            i_out.data.status, exp_r.status));
                end
            end
        end
    end
endmodule

>>> dv/testbench.sv
`timescale 1ns / 100ps
module testbench;
    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [23:0] cfg_wdata = '0;
    int          fail_count;
    int          pending;
    int          results_seen;
    int          send_idle_pct;
    int          sink_stall_pct;
    int          bytes_sent;
    int          produced_est;  // estimate of bytes written in the current stream, used to pick distances

    lzss_in_if  in_ch ();
    lzss_out_if out_ch ();

    always #1 i_clk = ~i_clk;

    lzss_flag_byte_decompressor_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_wdata (cfg_wdata),
        .i_in        (in_ch.sink),
        .o_out       (out_ch.source)
    );

    lzss_checker checker_i (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (cfg_we),
        .i_cfg_wdata    (cfg_wdata),
        .i_in           (in_ch),
        .i_out          (out_ch),
        .o_fail_count   (fail_count),
        .o_pending      (pending),
        .o_results_seen (results_seen)
    );

    initial begin
        in_ch.valid = 1'b0;
        in_ch.data  = '0;
        out_ch.ready = 1'b0;
    end

    // receiver back-pressure
    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // one compressed byte per transaction; valid stays up until the next
    // call or a pause in the stimulus drops it
    task automatic send_byte(input bit st, input logic [7:0] b, input bit lst);
        lzss_pkg::t_in it;
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        it.start_req = st; it.in_byte = b; it.last_in = lst;
        in_ch.data  <= it;
        in_ch.valid <= 1'b1;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic drain_and_write(input logic [23:0] sz);
        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        cfg_wdata <= sz;
        cfg_we    <= 1'b1;
        @(negedge i_clk);
        cfg_we    <= 1'b0;
    endtask

    // one token group: flag byte then up to eight tokens with random content
    task automatic send_group(input bit first, input bit far_ok, input bit lst);
        logic [7:0] fl;
        int unsigned d;
        fl = 8'($urandom_range(255));
        send_byte(first, fl, 1'b0);
        for (int t = 0; t < 8; t++) begin
            if (!fl[t] || produced_est == 0) begin
                if (fl[t]) begin
                    send_byte(1'b0, 8'($urandom_range(255)), 1'b0);
                    send_byte(1'b0, 8'($urandom_range(127)), lst && t == 7);
                    return;
                end
                send_byte(1'b0, 8'($urandom_range(255)), lst && t == 7);
                produced_est++;
            end else begin
                send_byte(1'b0, 8'(($urandom_range(3) == 0) ? $urandom_range(255)
                                                            : $urandom_range(12)), 1'b0);
                d = $urandom_range(1, (produced_est > 32768) ? 32768 : produced_est);
                if ($urandom_range(19) == 0) d = produced_est + 1;
                if (d <= 128 && far_ok == 0) begin
                    send_byte(1'b0, 8'(d - 1), lst && t == 7);
                end else begin
                    send_byte(1'b0, {1'b1, 7'((d - 1) >> 8)}, 1'b0);
                    send_byte(1'b0, 8'(d - 1), lst && t == 7);
                end
                produced_est += 4;
            end
        end
    endtask

    initial begin
        send_idle_pct = 0;
        sink_stall_pct = 0;
        bytes_sent = 0;
        produced_est = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // directed: reset size, literals, short and long matches, edge bytes
        send_byte(1, 8'h00, 0);
        send_byte(0, 8'hFF, 0);
        send_byte(0, 8'h00, 0);
        send_byte(0, 8'hFF, 0);
        send_byte(0, 8'h00, 0);
        send_byte(0, 8'h7F, 0);
        send_byte(0, 8'hFF, 0);
        send_byte(0, 8'hFF, 0);
        send_byte(0, 8'h80, 0);
        send_byte(0, 8'h01, 0);
        send_byte(0, 8'h05, 0);
        send_byte(0, 8'h80, 0);
        send_byte(0, 8'h00, 1);          // early end after the match
        send_byte(0, 8'h55, 0);          // ignored once finished
        // match before output start
        send_byte(1, 8'h01, 0);
        send_byte(0, 8'h00, 0);
        send_byte(0, 8'h00, 0);
        // zero size
        drain_and_write(24'd0);
        send_byte(1, 8'hAA, 1);
        // size 1: a single literal; size 5: match cut short; then maximum size
        drain_and_write(24'd1);
        send_byte(1, 8'h00, 0);
        send_byte(0, 8'h42, 0);
        drain_and_write(24'd5);
        send_byte(1, 8'h02, 0);
        send_byte(0, 8'h11, 0);
        send_byte(0, 8'hFF, 0);
        send_byte(0, 8'h00, 0);
        drain_and_write(24'hFFFFFF);

        // random streams across the idling phases
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin send_idle_pct = 0;  sink_stall_pct = 0;  end
                1: begin send_idle_pct = 75; sink_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  sink_stall_pct = 75; end
                default: begin send_idle_pct = 16; sink_stall_pct = 16; end
            endcase
            drain_and_write((ph == 1) ? 24'd40 : ((ph == 3) ? 24'd300 : 24'hFFFFFF));
            while (bytes_sent < 110 + ph * 100) begin
                produced_est = 0;
                send_group(1'b1, 1'($urandom_range(1)), 1'b0);
                repeat ($urandom_range(1, 3)) send_group(1'b0, 1'($urandom_range(1)), 1'b0);
                if ($urandom_range(3) == 0) send_byte(1'b0, 8'($urandom_range(255)), 1'b1);
                else if ($urandom_range(5) == 0)
                    send_byte(1'($urandom_range(1)), 8'($urandom_range(255)),
                              1'($urandom_range(1)));
            end
        end

        in_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (300) @(negedge i_clk);
        $display("Sent %0d compressed bytes and checked %0d results", bytes_sent, results_seen);
        $display("over seven unpacked sizes, both match forms, early ends and bad distances.");
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // run limit
    initial begin
        #4000000;
        $display("Test completed with failures");
        $finish;
    end
endmodule

>>> filelist.f
hw/rtl/lzss_pkg.sv
hw/rtl/lzss_if.sv
hw/rtl/lzss_ram.sv
hw/rtl/lzss_flag_byte_decompressor_top.sv
hw/rtl/lzss_checker.sv
dv/lzss_checker.sv
dv/testbench.sv
